// File: rtl/tno_pkg.sv
package tno_pkg;

    localparam int OPTION_COUNT_DEF = 256;

    typedef enum logic [2:0] {
        ST_NO          = 3'd0,
        ST_YES         = 3'd1,
        ST_WANTNO      = 3'd2,
        ST_WANTYES     = 3'd3,
        ST_WANTNO_OPP  = 3'd4,
        ST_WANTYES_OPP = 3'd5,
        ST_PENDING     = 3'd6
    } t_qstate;

    localparam logic [1:0] OP_RECEIVE  = 2'd0;
    localparam logic [1:0] OP_ANSWER   = 2'd1;
    localparam logic [1:0] OP_INITIATE = 2'd2;

    localparam logic [2:0] SND_NONE = 3'd0;
    localparam logic [2:0] SND_WILL = 3'd1;
    localparam logic [2:0] SND_WONT = 3'd2;
    localparam logic [2:0] SND_DO   = 3'd3;
    localparam logic [2:0] SND_DONT = 3'd4;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] command;
        logic [7:0] option_code;
    } t_in_item;

    typedef struct packed {
        logic       changed;
        logic [7:0] option_echo;
        logic       is_local_side;
        logic [2:0] new_state;
        logic [2:0] send_command;
        logic       protocol_error;
    } t_out_item;

endpackage

// File: rtl/tno_ram.sv
module tno_ram
#(
    parameter int WIDTH = 6,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/telnet_option_negotiation.sv
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   i_in  (t_in_item)
// out      output     o_out_valid / i_out_stall o_out (t_out_item)
//
// For each transaction the accept edge reads the option table, and the edge
// on which it completes modifies, writes back and registers the result.
// Synchronous active-low reset marks every table entry as NO for both sides.
// A stalled result is held in the output register; one transaction can wait
// in the read stage behind it.
module telnet_option_negotiation
    import tno_pkg::*;
#(
    parameter int OPTION_COUNT = OPTION_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int AW = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;

    logic              r_s1_valid, n_s1_valid;
    t_in_item          r_in, n_in;
    logic              r_in_range, n_in_range;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic [OPTION_COUNT-1:0] r_vld, n_vld;

    logic              in_accept;
    logic              done;
    logic [AW-1:0]     addr;
    logic [5:0]        rd_data;
    logic [5:0]        wr_data;
    logic              wr_en;
    logic              local_side;
    t_qstate           cur_loc, cur_peer, cur, ns;
    logic              keep;
    logic              err;
    logic [2:0]        snd, en_cmd, dis_cmd;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_valid;
    assign done = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign addr = r_in.option_code[AW-1:0];

    tno_ram #(
        .WIDTH (6),
        .DEPTH (OPTION_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_in.option_code[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        cur_loc  = ST_NO;
        cur_peer = ST_NO;
        if (r_in_range && r_vld[addr]) begin
            cur_loc  = t_qstate'(rd_data[5:3]);
            cur_peer = t_qstate'(rd_data[2:0]);
        end
        if (r_in.operation == OP_RECEIVE) begin
            local_side = r_in.command[1];
        end else begin
            local_side = !r_in.command[1];
        end
        cur     = local_side ? cur_loc : cur_peer;
        en_cmd  = r_in.command[1] ? SND_WILL : SND_DO;
        dis_cmd = r_in.command[1] ? SND_WONT : SND_DONT;
        keep    = 1'b0;
        ns      = ST_NO;
        snd     = SND_NONE;
        err     = 1'b0;

        unique case (r_in.operation)
            OP_RECEIVE: begin
                if (!r_in.command[0]) begin
                    case (cur)
                        ST_NO:          ns = ST_PENDING;
                        ST_WANTYES:     ns = ST_YES;
                        ST_WANTNO:      begin ns = ST_NO; err = 1'b1; end
                        ST_WANTYES_OPP: begin ns = ST_WANTNO; snd = dis_cmd; end
                        ST_WANTNO_OPP:  begin ns = ST_YES; err = 1'b1; end
                        default:        keep = 1'b1;
                    endcase
                end else begin
                    case (cur)
                        ST_YES:         begin ns = ST_NO; snd = dis_cmd; end
                        ST_WANTYES, ST_WANTNO, ST_WANTYES_OPP, ST_PENDING:
                            ns = ST_NO;
                        ST_WANTNO_OPP:  begin ns = ST_WANTYES; snd = en_cmd; end
                        default:        keep = 1'b1;
                    endcase
                end
            end
            OP_ANSWER: begin
                if (cur == ST_PENDING) begin
                    snd = {1'b0, r_in.command} + 3'd1;
                    ns  = r_in.command[0] ? ST_NO : ST_YES;
                end else begin
                    keep = 1'b1;
                end
            end
            OP_INITIATE: begin
                if (!r_in.command[0]) begin
                    case (cur)
                        ST_NO:          begin ns = ST_WANTYES; snd = {1'b0, r_in.command} + 3'd1; end
                        ST_WANTNO:      ns = ST_WANTNO_OPP;
                        ST_WANTYES_OPP: ns = ST_WANTYES;
                        default:        keep = 1'b1;
                    endcase
                end else begin
                    case (cur)
                        ST_YES:        begin ns = ST_WANTNO; snd = {1'b0, r_in.command} + 3'd1; end
                        ST_WANTYES:    ns = ST_WANTYES_OPP;
                        ST_WANTNO_OPP: ns = ST_WANTNO;
                        default:       keep = 1'b1;
                    endcase
                end
            end
            default: keep = 1'b1;
        endcase

        if (!r_in_range) begin
            keep = 1'b1;
        end

        wr_en   = done && !keep;
        wr_data = local_side ? {ns, cur_peer} : {cur_loc, ns};
    end

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_in        = r_in;
        n_in_range  = r_in_range;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_vld       = r_vld;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (done) begin
            n_s1_valid  = 1'b0;
            n_out_valid = 1'b1;
            n_out       = '0;
            if (!keep) begin
                n_out.changed        = 1'b1;
                n_out.option_echo    = r_in.option_code;
                n_out.is_local_side  = local_side;
                n_out.new_state      = ns;
                n_out.send_command   = snd;
                n_out.protocol_error = err;
                n_vld[addr]          = 1'b1;
            end
        end
        if (in_accept) begin
            n_s1_valid = 1'b1;
            n_in       = i_in;
            n_in_range = {1'b0, i_in.option_code} < 9'(OPTION_COUNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_vld       <= n_vld;
        end
        r_in       <= n_in;
        r_in_range <= n_in_range;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_in_stall && !in_accept))
        else $error("second transaction accepted while one is in the read stage");

    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_out_valid)
        else $error("completed transaction left no result");

    a_no_change_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.changed) |-> (o_out == '0))
        else $error("unchanged result carries nonzero fields");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_s1_valid && r_in_range))
        else $error("table write outside an in-range transaction");

endmodule

// File: sim/tb_telnet_option_negotiation.sv
`timescale 1ns / 1ps

module tb_telnet_option_negotiation;
    import tno_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] CMD_WILL  = 2'd0;
    localparam logic [1:0] CMD_WONT  = 2'd1;
    localparam logic [1:0] CMD_DO    = 2'd2;
    localparam logic [1:0] CMD_DONT  = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_TAIL   = 120;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in        = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    t_qstate   our_state [0:OPTION_COUNT_DEF-1];
    t_qstate   his_state [0:OPTION_COUNT_DEF-1];
    int        mismatch_count = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    logic      feed_idle_on = 1'b1;
    logic      drain_idle_on = 1'b1;
    logic      quiet_tail = 1'b0;

    telnet_option_negotiation DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [2:0] verb_code(input logic [1:0] cmd);
        case (cmd)
            CMD_WILL: verb_code = SND_WILL;
            CMD_WONT: verb_code = SND_WONT;
            CMD_DO:   verb_code = SND_DO;
            default:  verb_code = SND_DONT;
        endcase
    endfunction

    // Q-method step for one option side; updates the shadow table.
    function automatic t_out_item negotiate(input t_in_item it);
        t_out_item  res;
        t_qstate    cur;
        t_qstate    nxt;
        logic       on_ours;
        logic       hit;
        logic       err;
        logic [2:0] snd;
        logic [2:0] en_snd;
        logic [2:0] dis_snd;
        logic [1:0] cmd;
        res = '0;
        hit = 1'b0;
        err = 1'b0;
        snd = SND_NONE;
        nxt = ST_NO;
        cmd = it.command;
        if (it.operation == OP_UNUSED) begin
            return res;
        end
        if (it.operation == OP_RECEIVE) begin
            on_ours = (cmd == CMD_DO || cmd == CMD_DONT);
        end else begin
            on_ours = (cmd == CMD_WILL || cmd == CMD_WONT);
        end
        cur = on_ours ? our_state[it.option_code] : his_state[it.option_code];
        case (it.operation)
            OP_RECEIVE: begin
                if (cmd == CMD_WILL || cmd == CMD_DO) begin
                    dis_snd = (cmd == CMD_WILL) ? SND_DONT : SND_WONT;
                    hit = 1'b1;
                    case (cur)
                        ST_NO:          nxt = ST_PENDING;
                        ST_WANTYES:     nxt = ST_YES;
                        ST_WANTNO:      begin nxt = ST_NO; err = 1'b1; end
                        ST_WANTYES_OPP: begin nxt = ST_WANTNO; snd = dis_snd; end
                        ST_WANTNO_OPP:  begin nxt = ST_YES; err = 1'b1; end
                        default:        hit = 1'b0;
                    endcase
                end else begin
                    en_snd  = (cmd == CMD_WONT) ? SND_DO : SND_WILL;
                    dis_snd = (cmd == CMD_WONT) ? SND_DONT : SND_WONT;
                    hit = 1'b1;
                    case (cur)
                        ST_YES:        begin nxt = ST_NO; snd = dis_snd; end
                        ST_WANTYES, ST_WANTNO, ST_WANTYES_OPP, ST_PENDING: nxt = ST_NO;
                        ST_WANTNO_OPP: begin nxt = ST_WANTYES; snd = en_snd; end
                        default:       hit = 1'b0;
                    endcase
                end
            end
            OP_ANSWER: begin
                if (cur == ST_PENDING) begin
                    hit = 1'b1;
                    snd = verb_code(cmd);
                    nxt = (cmd == CMD_WILL || cmd == CMD_DO) ? ST_YES : ST_NO;
                end
            end
            default: begin
                hit = 1'b1;
                if (cmd == CMD_WILL || cmd == CMD_DO) begin
                    case (cur)
                        ST_NO:          begin nxt = ST_WANTYES; snd = verb_code(cmd); end
                        ST_WANTNO:      nxt = ST_WANTNO_OPP;
                        ST_WANTYES_OPP: nxt = ST_WANTYES;
                        default:        hit = 1'b0;
                    endcase
                end else begin
                    case (cur)
                        ST_YES:        begin nxt = ST_WANTNO; snd = verb_code(cmd); end
                        ST_WANTYES:    nxt = ST_WANTYES_OPP;
                        ST_WANTNO_OPP: nxt = ST_WANTNO;
                        default:       hit = 1'b0;
                    endcase
                end
            end
        endcase
        if (hit) begin
            if (on_ours) begin
                our_state[it.option_code] = nxt;
            end else begin
                his_state[it.option_code] = nxt;
            end
            res.changed        = 1'b1;
            res.option_echo    = it.option_code;
            res.is_local_side  = on_ours;
            res.new_state      = nxt;
            res.send_command   = snd;
            res.protocol_error = err;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_item(input logic [1:0] op, input logic [1:0] cmd,
                              input logic [7:0] opt);
        t_in_item it;
        it.operation   = op;
        it.command     = cmd;
        it.option_code = opt;
        pending_items.push_back(it);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            quiet_tail <= 1'b0;
        end else begin
            quiet_tail <= (pending_items.size() < QUIET_TAIL);
            if ($urandom_range(0, 63) == 0) begin
                feed_idle_on = ~feed_idle_on;
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(negotiate(i_in));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!quiet_tail && feed_idle_on && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in       <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : drain_proc
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", int'(o_out), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.changed !== want.changed)
                        report_mismatch("changed", int'(o_out.changed),
                                        int'(want.changed));
                    if (o_out.option_echo !== want.option_echo)
                        report_mismatch("option_echo", int'(o_out.option_echo),
                                        int'(want.option_echo));
                    if (o_out.is_local_side !== want.is_local_side)
                        report_mismatch("is_local_side", int'(o_out.is_local_side),
                                        int'(want.is_local_side));
                    if (o_out.new_state !== want.new_state)
                        report_mismatch("new_state", int'(o_out.new_state),
                                        int'(want.new_state));
                    if (o_out.send_command !== want.send_command)
                        report_mismatch("send_command", int'(o_out.send_command),
                                        int'(want.send_command));
                    if (o_out.protocol_error !== want.protocol_error)
                        report_mismatch("protocol_error", int'(o_out.protocol_error),
                                        int'(want.protocol_error));
                end
            end
            if ($urandom_range(0, 63) == 0) begin
                drain_idle_on = ~drain_idle_on;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet_tail && drain_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] pool[4];
        logic [1:0] op;
        logic [7:0] opt;
        int         roll;
        for (int k = 0; k < OPTION_COUNT_DEF; k++) begin
            our_state[k] = ST_NO;
            his_state[k] = ST_NO;
        end

        // peer side of option 0 through every state
        queue_item(OP_RECEIVE,  CMD_WILL, 8'd0);
        queue_item(OP_RECEIVE,  CMD_WILL, 8'd0);
        queue_item(OP_ANSWER,   CMD_DO,   8'd0);
        queue_item(OP_ANSWER,   CMD_DO,   8'd0);
        queue_item(OP_RECEIVE,  CMD_WONT, 8'd0);
        queue_item(OP_INITIATE, CMD_DO,   8'd0);
        queue_item(OP_INITIATE, CMD_DONT, 8'd0);
        queue_item(OP_INITIATE, CMD_DO,   8'd0);
        queue_item(OP_INITIATE, CMD_DONT, 8'd0);
        queue_item(OP_RECEIVE,  CMD_WILL, 8'd0);
        queue_item(OP_INITIATE, CMD_DO,   8'd0);
        queue_item(OP_RECEIVE,  CMD_WILL, 8'd0);
        queue_item(OP_INITIATE, CMD_DONT, 8'd0);
        queue_item(OP_INITIATE, CMD_DO,   8'd0);
        queue_item(OP_RECEIVE,  CMD_WONT, 8'd0);
        // local side of option 255, then of options 128 and 127
        queue_item(OP_INITIATE, CMD_WILL, 8'd255);
        queue_item(OP_RECEIVE,  CMD_DO,   8'd255);
        queue_item(OP_INITIATE, CMD_WILL, 8'd255);
        queue_item(OP_RECEIVE,  CMD_DONT, 8'd255);
        queue_item(OP_RECEIVE,  CMD_DO,   8'd255);
        queue_item(OP_ANSWER,   CMD_WONT, 8'd255);
        queue_item(OP_UNUSED,   CMD_DONT, 8'd255);
        queue_item(OP_RECEIVE,  CMD_DONT, 8'd128);
        queue_item(OP_INITIATE, CMD_WONT, 8'd127);

        // random, mostly hammering a few options so states go deep
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                for (int k = 0; k < 4; k++) pool[k] = 8'($urandom_range(0, 255));
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = OP_UNUSED;
            end else begin
                op = 2'($urandom_range(0, 2));
            end
            if (roll >= 85) begin
                opt = 8'($urandom_range(0, 255));
            end else begin
                opt = pool[$urandom_range(0, 3)];
            end
            queue_item(op, 2'($urandom_range(0, 3)), opt);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            report_mismatch("results left over", expected_results.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
